// ===== rtl/core/hsd_pkg.sv =====
// shared types and constants for the headset detect and button debounce block
// no dependencies; rtl files use scoped names, verif files import it
package hsd_pkg;

    localparam int CFG_W  = 12;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_INS   = 2'd0;
    localparam logic [1:0] REG_REM   = 2'd1;
    localparam logic [1:0] REG_BTN   = 2'd2;
    localparam logic [1:0] REG_PROBE = 2'd3;

    localparam logic [CFG_W-1:0] INS_RST   = 12'd100;
    localparam logic [CFG_W-1:0] REM_RST   = 12'd20;
    localparam logic [CFG_W-1:0] BTN_RST   = 12'd10;
    localparam logic [CFG_W-1:0] PROBE_RST = 12'd10;

    // probe phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_DRIVE  = 2'd1;
    localparam logic [1:0] PH_DECIDE = 2'd2;
    localparam logic [1:0] PH_SPARE  = 2'd3;

    // event codes, shared by key and plug events
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    typedef struct packed {
        logic detect_level;
        logic button_level;
        logic clock_level;
    } item_t;

    typedef struct packed {
        logic       headset_present;
        logic       button_down;
        logic       route_to_gpio;
        logic       probe_drive;
        logic [1:0] key_event;
        logic [1:0] plug_event;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] ins;
        logic [CFG_W-1:0] rem;
        logic [CFG_W-1:0] btn;
        logic [CFG_W-1:0] probe;
    } cfg_t;

endpackage

// ===== rtl/core/hsd_cfg.sv =====
// configuration register bank behind an apb-style port
// depends on hsd_pkg
module hsd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsd_pkg::DATA_W-1:0]  pwdata,
    output logic [hsd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output hsd_pkg::cfg_t               cfg
);

    logic [hsd_pkg::CFG_W-1:0] ins_reg;
    logic [hsd_pkg::CFG_W-1:0] rem_reg;
    logic [hsd_pkg::CFG_W-1:0] btn_reg;
    logic [hsd_pkg::CFG_W-1:0] probe_reg;
    logic                      wr_en;
    logic [1:0]                idx;
    logic [hsd_pkg::CFG_W-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg   <= hsd_pkg::INS_RST;
            rem_reg   <= hsd_pkg::REM_RST;
            btn_reg   <= hsd_pkg::BTN_RST;
            probe_reg <= hsd_pkg::PROBE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                hsd_pkg::REG_INS:   ins_reg   <= pwdata[hsd_pkg::CFG_W-1:0];
                hsd_pkg::REG_REM:   rem_reg   <= pwdata[hsd_pkg::CFG_W-1:0];
                hsd_pkg::REG_BTN:   btn_reg   <= pwdata[hsd_pkg::CFG_W-1:0];
                hsd_pkg::REG_PROBE: probe_reg <= pwdata[hsd_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            hsd_pkg::REG_INS:   rd_val = ins_reg;
            hsd_pkg::REG_REM:   rd_val = rem_reg;
            hsd_pkg::REG_BTN:   rd_val = btn_reg;
            hsd_pkg::REG_PROBE: rd_val = probe_reg;
        endcase
    end

    assign prdata = {{(hsd_pkg::DATA_W-hsd_pkg::CFG_W){1'b0}}, rd_val};

    assign cfg.ins   = ins_reg;
    assign cfg.rem   = rem_reg;
    assign cfg.btn   = btn_reg;
    assign cfg.probe = probe_reg;

endmodule

// ===== rtl/core/hsd_tick.sv =====
// per-tick state: detect and button debounce timers, probe sequence, flags
// depends on hsd_pkg; result is the combinational outcome of the current tick
module hsd_tick #(
    parameter int TIMER_WIDTH = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hsd_pkg::item_t   item,
    input  hsd_pkg::cfg_t    cfg,
    output hsd_pkg::result_t result
);

    localparam logic [TIMER_WIDTH-1:0] ONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

    logic                   present_reg, present_next;
    logic                   button_reg, button_next;
    logic                   ignore_reg, ignore_next;
    logic                   route_reg, route_next;
    logic [TIMER_WIDTH-1:0] det_cnt_reg, det_cnt_next;
    logic                   det_run_reg, det_run_next;
    logic [TIMER_WIDTH-1:0] btn_cnt_reg, btn_cnt_next;
    logic                   btn_run_reg, btn_run_next;
    logic [1:0]             phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] probe_cnt_reg, probe_cnt_next;
    logic                   latched_reg, latched_next;
    logic                   last_det_reg, last_det_next;
    logic                   last_btn_reg, last_btn_next;
    logic [1:0]             key_ev;
    logic [1:0]             plug_ev;

    // register value masked to the timer width, zero counts as one
    function automatic logic [TIMER_WIDTH-1:0] load_len(input logic [hsd_pkg::CFG_W-1:0] v);
        logic [31:0]            wide;
        logic [TIMER_WIDTH-1:0] t;
        begin
            wide = {{(32-hsd_pkg::CFG_W){1'b0}}, v};
            t    = wide[TIMER_WIDTH-1:0];
            if (t == '0)
                t = ONE;
            return t;
        end
    endfunction

    always_comb
    begin
        present_next   = present_reg;
        button_next    = button_reg;
        ignore_next    = ignore_reg;
        route_next     = route_reg;
        det_cnt_next   = det_cnt_reg;
        det_run_next   = det_run_reg;
        btn_cnt_next   = btn_cnt_reg;
        btn_run_next   = btn_run_reg;
        phase_next     = phase_reg;
        probe_cnt_next = probe_cnt_reg;
        latched_next   = latched_reg;
        last_det_next  = last_det_reg;
        last_btn_next  = last_btn_reg;
        key_ev         = hsd_pkg::EV_NONE;
        plug_ev        = hsd_pkg::EV_NONE;

        if (phase_next == hsd_pkg::PH_SPARE)
            phase_next = hsd_pkg::PH_IDLE;

        // probe decision, one tick after the drive ends
        if (phase_next == hsd_pkg::PH_DECIDE)
        begin
            phase_next = hsd_pkg::PH_IDLE;
            if (!item.detect_level && !latched_reg)
            begin
                if (!present_next)
                begin
                    present_next = 1'b1;
                    route_next   = 1'b1;
                    ignore_next  = !item.button_level;
                    plug_ev      = hsd_pkg::EV_ON;
                end
            end
            else
            begin
                route_next = 1'b0;
            end
        end

        if (phase_next == hsd_pkg::PH_DRIVE)
        begin
            probe_cnt_next = probe_cnt_next - ONE;
            if (probe_cnt_next == '0)
            begin
                latched_next = item.clock_level;
                phase_next   = hsd_pkg::PH_DECIDE;
            end
        end

        if (det_run_next)
        begin
            det_cnt_next = det_cnt_next - ONE;
            if (det_cnt_next == '0)
            begin
                det_run_next = 1'b0;
                if (phase_next == hsd_pkg::PH_IDLE)
                begin
                    if (item.detect_level)
                    begin
                        if (present_next)
                        begin
                            present_next = 1'b0;
                            route_next   = 1'b0;
                            plug_ev      = hsd_pkg::EV_OFF;
                            if (button_next)
                            begin
                                button_next = 1'b0;
                                key_ev      = hsd_pkg::EV_OFF;
                            end
                        end
                    end
                    else
                    begin
                        route_next     = 1'b1;
                        phase_next     = hsd_pkg::PH_DRIVE;
                        probe_cnt_next = load_len(cfg.probe);
                    end
                end
            end
        end

        if (btn_run_next)
        begin
            btn_cnt_next = btn_cnt_next - ONE;
            if (btn_cnt_next == '0)
            begin
                btn_run_next = 1'b0;
                if (present_next)
                begin
                    if (item.button_level)
                    begin
                        if (ignore_next)
                        begin
                            ignore_next = 1'b0;
                        end
                        else if (button_next)
                        begin
                            button_next = 1'b0;
                            key_ev      = hsd_pkg::EV_OFF;
                        end
                    end
                    else if (!ignore_next && !button_next)
                    begin
                        button_next = 1'b1;
                        key_ev      = hsd_pkg::EV_ON;
                    end
                end
            end
        end

        // detect pin changes are not seen while probing
        if (phase_next == hsd_pkg::PH_IDLE && item.detect_level != last_det_next)
        begin
            last_det_next = item.detect_level;
            if ((!present_next) != item.detect_level)
            begin
                if (present_next)
                    ignore_next = 1'b1;
                det_cnt_next = load_len(present_next ? cfg.rem : cfg.ins);
                det_run_next = 1'b1;
            end
        end

        if (present_next && item.button_level != last_btn_next)
        begin
            last_btn_next = item.button_level;
            btn_cnt_next  = load_len(cfg.btn);
            btn_run_next  = 1'b1;
        end

        result.headset_present = present_next;
        result.button_down     = button_next;
        result.route_to_gpio   = route_next;
        result.probe_drive     = (phase_next == hsd_pkg::PH_DRIVE);
        result.key_event       = key_ev;
        result.plug_event      = plug_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 1'b0;
            button_reg    <= 1'b0;
            ignore_reg    <= 1'b0;
            route_reg     <= 1'b0;
            det_cnt_reg   <= '0;
            det_run_reg   <= 1'b0;
            btn_cnt_reg   <= '0;
            btn_run_reg   <= 1'b0;
            phase_reg     <= hsd_pkg::PH_IDLE;
            probe_cnt_reg <= '0;
            latched_reg   <= 1'b0;
            last_det_reg  <= 1'b1;
            last_btn_reg  <= 1'b1;
        end
        else if (step)
        begin
            present_reg   <= present_next;
            button_reg    <= button_next;
            ignore_reg    <= ignore_next;
            route_reg     <= route_next;
            det_cnt_reg   <= det_cnt_next;
            det_run_reg   <= det_run_next;
            btn_cnt_reg   <= btn_cnt_next;
            btn_run_reg   <= btn_run_next;
            phase_reg     <= phase_next;
            probe_cnt_reg <= probe_cnt_next;
            latched_reg   <= latched_next;
            last_det_reg  <= last_det_next;
            last_btn_reg  <= last_btn_next;
        end
    end

    a_det_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        det_run_reg |-> det_cnt_reg != '0)
        else $error("detect timer running with zero count");

    a_btn_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        btn_run_reg |-> btn_cnt_reg != '0)
        else $error("button timer running with zero count");

    a_drive_routes_gpio: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hsd_pkg::PH_DRIVE |-> route_reg)
        else $error("probe drive without gpio routing");

    a_removal_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.plug_event == hsd_pkg::EV_OFF |=> !present_reg && !button_reg)
        else $error("removal left headset or button set");

    a_press_needs_headset: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.key_event == hsd_pkg::EV_ON |=> present_reg && button_reg)
        else $error("button press without headset");

endmodule

// ===== rtl/core/headset_detect_button_debounce.sv =====
// headset insertion/removal detection with media button debounce
// one input beat is one timebase tick; each tick gives exactly one result beat
// with the status after that tick and the key and plug events it raised
// input channel: in_valid / in_stall with detect_level, button_level, clock_level
// output channel: out_valid / out_stall with headset_present, button_down,
// route_to_gpio, probe_drive, key_event, plug_event
// a beat that is accepted waits in the input register, is evaluated into the
// result register when the result slot is free or drained, and then shows on
// out_valid; one beat per cycle is taken and delivered when out_stall is low
// while out_stall holds a result, one more beat waits in the input register,
// then in_stall rises until the result is taken
// timer and probe lengths come from four registers on the apb port
// (insertion, removal, button debounce, probe drive ticks); write them idle
// reset clears all flags, timers and pending beats and loads register defaults
// (100, 20, 10, 10 ticks); no clearing pass is needed
module headset_detect_button_debounce #(
    parameter int TIMER_WIDTH = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsd_pkg::DATA_W-1:0]  pwdata,
    output logic [hsd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        detect_level,
    input  logic                        button_level,
    input  logic                        clock_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        headset_present,
    output logic                        button_down,
    output logic                        route_to_gpio,
    output logic                        probe_drive,
    output logic [1:0]                  key_event,
    output logic [1:0]                  plug_event
);

    hsd_pkg::cfg_t    cfg;
    hsd_pkg::item_t   item_reg;
    hsd_pkg::result_t result;
    hsd_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step;
    logic             in_take;

    hsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsd_tick #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tick (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // result slot is free or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.detect_level <= detect_level;
            item_reg.button_level <= button_level;
            item_reg.clock_level  <= clock_level;
        end
        if (step)
            out_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign headset_present = out_reg.headset_present;
    assign button_down     = out_reg.button_down;
    assign route_to_gpio   = out_reg.route_to_gpio;
    assign probe_drive     = out_reg.probe_drive;
    assign key_event       = out_reg.key_event;
    assign plug_event      = out_reg.plug_event;

endmodule

// ===== verif/hsd_result_checker.sv =====
// result checker for the headset detect and button debounce block
// tracks apb register writes, predicts one status beat per input tick and compares
// depends on hsd_pkg for register indexes, probe phase and event codes
module hsd_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsd_pkg::DATA_W-1:0]  pwdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        detect_level,
    input  logic                        button_level,
    input  logic                        clock_level,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        headset_present,
    input  logic                        button_down,
    input  logic                        route_to_gpio,
    input  logic                        probe_drive,
    input  logic [1:0]                  key_event,
    input  logic [1:0]                  plug_event,
    output int                          fail_count,
    output int                          pending,
    output int                          insert_count,
    output int                          remove_count,
    output int                          key_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsd_pkg::*;

    localparam int MAX_REPORTS = 30;

    logic [CFG_W-1:0] ins_cfg, rem_cfg, btn_cfg, probe_cfg;

    logic             hs_present, hs_button, hs_ignore, hs_route;
    logic [CFG_W-1:0] det_cnt, btn_cnt, probe_cnt;
    logic             det_run, btn_run;
    logic [1:0]       probe_ph;
    logic             clk_latch, prev_det, prev_btn;

    result_t status_q[$];

    function automatic logic [CFG_W-1:0] timer_load(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

    // advance the debounce state by one tick and form the status beat after it
    task automatic predict_tick(input item_t tk, output result_t r);
        logic [1:0] key_ev;
        logic [1:0] plug_ev;
        key_ev  = EV_NONE;
        plug_ev = EV_NONE;

        if (probe_ph == PH_SPARE)
            probe_ph = PH_IDLE;

        if (probe_ph == PH_DECIDE)
        begin
            probe_ph = PH_IDLE;
            if (!tk.detect_level && !clk_latch)
            begin
                if (!hs_present)
                begin
                    hs_present = 1'b1;
                    hs_route   = 1'b1;
                    hs_ignore  = !tk.button_level;
                    plug_ev    = EV_ON;
                end
            end
            else
                hs_route = 1'b0;
        end

        if (probe_ph == PH_DRIVE)
        begin
            probe_cnt = probe_cnt - 1'b1;
            if (probe_cnt == '0)
            begin
                clk_latch = tk.clock_level;
                probe_ph  = PH_DECIDE;
            end
        end

        if (det_run)
        begin
            det_cnt = det_cnt - 1'b1;
            if (det_cnt == '0)
            begin
                det_run = 1'b0;
                if (probe_ph == PH_IDLE)
                begin
                    if (tk.detect_level)
                    begin
                        if (hs_present)
                        begin
                            hs_present = 1'b0;
                            hs_route   = 1'b0;
                            plug_ev    = EV_OFF;
                            if (hs_button)
                            begin
                                hs_button = 1'b0;
                                key_ev    = EV_OFF;
                            end
                        end
                    end
                    else
                    begin
                        hs_route  = 1'b1;
                        probe_ph  = PH_DRIVE;
                        probe_cnt = timer_load(probe_cfg);
                    end
                end
            end
        end

        if (btn_run)
        begin
            btn_cnt = btn_cnt - 1'b1;
            if (btn_cnt == '0)
            begin
                btn_run = 1'b0;
                if (hs_present)
                begin
                    if (tk.button_level)
                    begin
                        if (hs_ignore)
                            hs_ignore = 1'b0;
                        else if (hs_button)
                        begin
                            hs_button = 1'b0;
                            key_ev    = EV_OFF;
                        end
                    end
                    else if (!hs_ignore && !hs_button)
                    begin
                        hs_button = 1'b1;
                        key_ev    = EV_ON;
                    end
                end
            end
        end

        // detect edges are masked while probing, so prev_det holds its old level
        if (probe_ph == PH_IDLE && tk.detect_level != prev_det)
        begin
            prev_det = tk.detect_level;
            if (!hs_present != tk.detect_level)
            begin
                if (hs_present)
                    hs_ignore = 1'b1;
                det_cnt = timer_load(hs_present ? rem_cfg : ins_cfg);
                det_run = 1'b1;
            end
        end

        if (hs_present && tk.button_level != prev_btn)
        begin
            prev_btn = tk.button_level;
            btn_cnt  = timer_load(btn_cfg);
            btn_run  = 1'b1;
        end

        r.headset_present = hs_present;
        r.button_down     = hs_button;
        r.route_to_gpio   = hs_route;
        r.probe_drive     = (probe_ph == PH_DRIVE);
        r.key_event       = key_ev;
        r.plug_event      = plug_ev;
    endtask

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track_proc
        item_t   tick_in;
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            ins_cfg    = INS_RST;
            rem_cfg    = REM_RST;
            btn_cfg    = BTN_RST;
            probe_cfg  = PROBE_RST;
            hs_present = 1'b0;
            hs_button  = 1'b0;
            hs_ignore  = 1'b0;
            hs_route   = 1'b0;
            det_cnt    = '0;
            det_run    = 1'b0;
            btn_cnt    = '0;
            btn_run    = 1'b0;
            probe_ph   = PH_IDLE;
            probe_cnt  = '0;
            clk_latch  = 1'b0;
            prev_det   = 1'b1;
            prev_btn   = 1'b1;
            status_q.delete();
            fail_count   = 0;
            insert_count = 0;
            remove_count = 0;
            key_count    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_INS:   ins_cfg   = pwdata[CFG_W-1:0];
                    REG_REM:   rem_cfg   = pwdata[CFG_W-1:0];
                    REG_BTN:   btn_cfg   = pwdata[CFG_W-1:0];
                    REG_PROBE: probe_cfg = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                tick_in.detect_level = detect_level;
                tick_in.button_level = button_level;
                tick_in.clock_level  = clock_level;
                predict_tick(tick_in, want);
                status_q.push_back(want);
                if (want.plug_event == EV_ON)
                    insert_count++;
                if (want.plug_event == EV_OFF)
                    remove_count++;
                if (want.key_event != EV_NONE)
                    key_count++;
            end

            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: status beat with none expected, expected nothing, got %h",
                                 $time, {headset_present, button_down, route_to_gpio,
                                         probe_drive, key_event, plug_event});
                end
                else
                begin
                    want = status_q.pop_front();
                    seen.headset_present = headset_present;
                    seen.button_down     = button_down;
                    seen.route_to_gpio   = route_to_gpio;
                    seen.probe_drive     = probe_drive;
                    seen.key_event       = key_event;
                    seen.plug_event      = plug_event;
                    check_field("headset_present", 2'(want.headset_present),
                                2'(seen.headset_present));
                    check_field("button_down", 2'(want.button_down), 2'(seen.button_down));
                    check_field("route_to_gpio", 2'(want.route_to_gpio),
                                2'(seen.route_to_gpio));
                    check_field("probe_drive", 2'(want.probe_drive), 2'(seen.probe_drive));
                    check_field("key_event", want.key_event, seen.key_event);
                    check_field("plug_event", want.plug_event, seen.plug_event);
                end
            end
        end
        pending <= status_q.size();
    end

endmodule

// ===== verif/headset_detect_button_debounce_tb.sv =====
// top of the headset detect testbench: clock, reset, apb register writes and tick stimulus
// depends on hsd_pkg, the block and hsd_result_checker, which does all the comparing
module headset_detect_button_debounce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsd_pkg::*;

    localparam int RANDOM_TICKS = 1100;
    localparam int ROUND_TICKS  = 250;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                detect_level = 1'b1;
    logic                button_level = 1'b1;
    logic                clock_level  = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                headset_present;
    logic                button_down;
    logic                route_to_gpio;
    logic                probe_drive;
    logic [1:0]          key_event;
    logic [1:0]          plug_event;

    int fail_count, pending, insert_count, remove_count, key_count;

    int send_pct = 0;
    int recv_pct = 0;
    int ticks_sent = 0;
    int settings_count = 0;
    int random_start, next_change, round_idx, waited, rel;

    logic [CFG_W-1:0] cur_cfg [4] = '{INS_RST, REM_RST, BTN_RST, PROBE_RST};

    // {detect, button, clock} per tick, with every timer at one tick
    bit [2:0] directed_ticks [0:23] = '{
        3'b010, 3'b010, 3'b010,     // insertion debounce, probe drive, clock latched low
        3'b000, 3'b000,             // inserted with button held: press is ignored
        3'b010, 3'b010,             // release clears the ignore flag
        3'b000, 3'b000, 3'b000,     // real press
        3'b100, 3'b100,             // removal with button down
        3'b001, 3'b001, 3'b101,     // probe with clock high, detect edge while probing
        3'b101,                     // probe fails
        3'b010, 3'b010, 3'b010, 3'b010,
        3'b110, 3'b010,             // detect glitch while present starts a probe
        3'b010, 3'b110              // failed probe keeps the headset
    };

    headset_detect_button_debounce u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .detect_level    (detect_level),
        .button_level    (button_level),
        .clock_level     (clock_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .headset_present (headset_present),
        .button_down     (button_down),
        .route_to_gpio   (route_to_gpio),
        .probe_drive     (probe_drive),
        .key_event       (key_event),
        .plug_event      (plug_event)
    );

    hsd_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .detect_level    (detect_level),
        .button_level    (button_level),
        .clock_level     (clock_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .headset_present (headset_present),
        .button_down     (button_down),
        .route_to_gpio   (route_to_gpio),
        .probe_drive     (probe_drive),
        .key_event       (key_event),
        .plug_event      (plug_event),
        .fail_count      (fail_count),
        .pending         (pending),
        .insert_count    (insert_count),
        .remove_count    (remove_count),
        .key_count       (key_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_pct);

    function automatic int span(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int shorter(input int len);
        return (len > 1) ? int'($urandom_range(1, len - 1)) : 1;
    endfunction

    task automatic send_tick(input bit d, input bit b, input bit c);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        detect_level <= d;
        button_level <= b;
        clock_level  <= c;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    task automatic hold_ticks(input bit d, input bit b, input bit clk_rand, input int n);
        repeat (n)
            send_tick(d, b, clk_rand ? bit'($urandom_range(0, 1)) : 1'b0);
    endtask

    task automatic noise_ticks(input int n);
        repeat (n)
            send_tick(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                      bit'($urandom_range(0, 1)));
    endtask

    // stop sending first, so that a beat taken at the last edge already counts as pending
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(DATA_W - CFG_W)'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_cfg[idx] = val;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] ins, input logic [CFG_W-1:0] rem,
                                 input logic [CFG_W-1:0] btn, input logic [CFG_W-1:0] probe);
        drain_results();
        cfg_write(REG_INS, ins);
        cfg_write(REG_REM, rem);
        cfg_write(REG_BTN, btn);
        cfg_write(REG_PROBE, probe);
        settings_count++;
    endtask

    // plug in, work the button for a while, pull out
    task automatic plug_session(input int max_actions);
        int ins_len, rem_len, btn_len, probe_len;
        bit btn_now, clk_bad, det_bad;
        ins_len   = span(cur_cfg[REG_INS]);
        rem_len   = span(cur_cfg[REG_REM]);
        btn_len   = span(cur_cfg[REG_BTN]);
        probe_len = span(cur_cfg[REG_PROBE]);
        btn_now   = ($urandom_range(0, 3) != 0);
        clk_bad   = ($urandom_range(0, 7) == 0);
        det_bad   = ($urandom_range(0, 7) == 0);

        noise_ticks($urandom_range(0, 3));
        send_tick(1'b1, btn_now, 1'b0);
        hold_ticks(1'b0, btn_now, 1'b0, ins_len + probe_len);
        send_tick(1'b0, btn_now, clk_bad);
        send_tick(det_bad, btn_now, bit'($urandom_range(0, 1)));
        hold_ticks(1'b0, btn_now, 1'b1, $urandom_range(0, 2));

        repeat ($urandom_range(1, max_actions))
        begin
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    btn_now = !btn_now;
                    hold_ticks(1'b0, btn_now, 1'b1, btn_len + $urandom_range(0, 3));
                end
                3:
                begin
                    // button bounce shorter than the debounce
                    hold_ticks(1'b0, !btn_now, 1'b1, shorter(btn_len));
                    hold_ticks(1'b0, btn_now, 1'b1, btn_len + 1);
                end
                4:
                begin
                    // detect glitch: sets ignore, may also start a probe
                    hold_ticks(1'b1, btn_now, 1'b1, shorter(rem_len));
                    hold_ticks(1'b0, btn_now, 1'b1, btn_len + probe_len + 3);
                end
                default:
                    hold_ticks(1'b0, btn_now, 1'b1, $urandom_range(1, 3));
            endcase
        end

        hold_ticks(1'b1, btn_now, 1'b1, rem_len + $urandom_range(1, 3));
        if (!btn_now)
            hold_ticks(1'b1, 1'b1, 1'b1, $urandom_range(1, 3));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 21;
        recv_pct = 48;
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        apply_setting(12'd1, 12'd1, 12'd1, 12'd1);
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i][2], directed_ticks[i][1], directed_ticks[i][0]);

        random_start = ticks_sent;
        next_change  = ticks_sent;
        round_idx    = 0;
        while (ticks_sent - random_start < RANDOM_TICKS)
        begin
            rel = ticks_sent - random_start;
            if (rel < RANDOM_TICKS / 3)
            begin
                send_pct = 21;
                recv_pct = 48;
            end
            else if (rel < 2 * RANDOM_TICKS / 3)
            begin
                send_pct = 48;
                recv_pct = 21;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end

            if (ticks_sent >= next_change)
            begin
                case (round_idx)
                    0: apply_setting(12'd0, 12'd0, 12'd0, 12'd0);
                    1: apply_setting(12'd1, 12'd1, 12'd1, 12'd1);
                    2: apply_setting(12'd5, 12'd3, 12'd2, 12'd4);
                    default:
                        apply_setting(12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)),
                                      12'($urandom_range(1, 6)), 12'($urandom_range(1, 6)));
                endcase
                round_idx++;
                next_change = ticks_sent + ROUND_TICKS;
            end

            if ($urandom_range(0, 4) == 0)
                noise_ticks($urandom_range(1, 20));
            else
                plug_session(6);
        end

        // long timers once, with both sides at full rate
        send_pct = 0;
        recv_pct = 0;
        apply_setting(12'd150, 12'd90, 12'd60, 12'd40);
        plug_session(1);

        in_valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; pending != 0 && waited < 50000; waited++)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d ticks over %0d register settings",
                 ticks_sent, settings_count);
        $display("predicted %0d insertions, %0d removals and %0d key events",
                 insert_count, remove_count, key_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== headset_detect_button_debounce.f =====
rtl/core/hsd_pkg.sv
rtl/core/hsd_cfg.sv
rtl/core/hsd_tick.sv
rtl/core/headset_detect_button_debounce.sv
verif/hsd_result_checker.sv
verif/headset_detect_button_debounce_tb.sv
